// ----- rtl/pcr_pkg.sv -----
// pcr_pkg: widths, payload types and helper functions for the particle contact resolver
// used by the channel interfaces, the divider pipeline and the top level
`default_nettype none

package pcr_pkg;

  localparam int CW    = 21;            // bits per vector component
  localparam int FB    = 10;            // fraction bits per component
  localparam int VW    = 3 * CW;        // packed vector
  localparam int IMW   = 24;            // inverse mass
  localparam int EW    = 17;            // restitution
  localparam int TW    = 16;            // time step
  localparam logic [TW-1:0] TIME_STEP_RESET = TW'(1092);

  localparam int DW    = IMW + 1;       // total inverse mass, divisor
  localparam int NMW   = 2 * CW + 5;    // magnitude of the impulse numerator
  localparam int QW    = NMW;           // quotient bits
  localparam int DVD   = QW + DW - 1;   // dividend bits
  localparam int PW    = 2 * CW + 1;    // component difference times normal
  localparam int DOTW  = PW + 2;        // dot product
  localparam int ACCW  = DOTW + TW + 1; // acceleration dot times time step
  localparam int TDTW  = ACCW + 1;      // second time step product
  localparam int SEPW  = NMW + 1;       // separating velocity
  localparam int FACW  = EW + 2;        // one plus restitution
  localparam int NPW   = SEPW + FACW;   // numerator product
  localparam int QSW   = QW + 1;        // signed impulse scalar
  localparam int QPW   = QSW + CW;      // impulse scalar times normal
  localparam int SUMW  = QPW - 2 * FB + 1;
  localparam int PROD_LIM_SH = 62;

  typedef struct packed {
    logic [VW-1:0]  vel_a;
    logic [VW-1:0]  vel_b;
    logic [VW-1:0]  pos_a;
    logic [VW-1:0]  pos_b;
    logic [VW-1:0]  nrm;
    logic [IMW-1:0] im_a;
    logic [DW-1:0]  den;
    logic [EW-1:0]  e;
    logic [CW-1:0]  p;
    logic           has;
  } carry_t;

  typedef struct packed {
    logic [VW-1:0]  vel_a;
    logic [VW-1:0]  vel_b;
    logic [VW-1:0]  pos_a;
    logic [VW-1:0]  pos_b;
    logic [VW-1:0]  nrm;
    logic           has;
    logic           den_zero;
    logic           pneg;
    logic           nneg;
    logic [NMW-1:0] nmag;
    logic [CW-2:0]  pmag;
  } side_t;

  function automatic logic signed [CW-1:0] comp_get(input logic [VW-1:0] w,
                                                    input int unsigned i);
    return w[i*CW +: CW];
  endfunction

  function automatic logic [CW-1:0] sat_c(input logic signed [SUMW-1:0] x);
    logic signed [SUMW-1:0] cmax;
    logic signed [SUMW-1:0] cmin;
    logic [CW-1:0]          r;
    cmax = SUMW'((64'sd1 <<< (CW - 1)) - 64'sd1);
    cmin = -cmax - SUMW'(1);
    if (x > cmax) begin
      r = cmax[CW-1:0];
    end else if (x < cmin) begin
      r = cmin[CW-1:0];
    end else begin
      r = x[CW-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/pcr_if.sv -----
// pcr_if: valid/ready channels for contact beats in and result beats out
// depends on pcr_pkg for the payload widths
`default_nettype none

interface pcr_contact_if;
  import pcr_pkg::*;
  logic           valid;
  logic           ready;
  logic [VW-1:0]  vel_a;
  logic [VW-1:0]  vel_b;
  logic [VW-1:0]  acc_a;
  logic [VW-1:0]  acc_b;
  logic [VW-1:0]  pos_a;
  logic [VW-1:0]  pos_b;
  logic [VW-1:0]  contact_normal;
  logic [IMW-1:0] inv_mass_a;
  logic [IMW-1:0] inv_mass_b;
  logic [EW-1:0]  restitution;
  logic signed [CW-1:0] penetration_depth;
  logic           has_b;

  modport source (output valid, vel_a, vel_b, acc_a, acc_b, pos_a, pos_b, contact_normal,
                  inv_mass_a, inv_mass_b, restitution, penetration_depth, has_b,
                  input ready);
  modport sink (input valid, vel_a, vel_b, acc_a, acc_b, pos_a, pos_b, contact_normal,
                inv_mass_a, inv_mass_b, restitution, penetration_depth, has_b,
                output ready);
endinterface

interface pcr_result_if;
  import pcr_pkg::*;
  logic          valid;
  logic          ready;
  logic [VW-1:0] new_vel_a;
  logic [VW-1:0] new_vel_b;
  logic [VW-1:0] new_pos_a;
  logic [VW-1:0] new_pos_b;

  modport source (output valid, new_vel_a, new_vel_b, new_pos_a, new_pos_b, input ready);
  modport sink (input valid, new_vel_a, new_vel_b, new_pos_a, new_pos_b, output ready);
endinterface

`default_nettype wire

// ----- rtl/pcr_div_pipe.sv -----
// pcr_div_pipe: two-lane restoring divider, one quotient bit per register stage
// shares one divisor between lanes and carries a sideband; depends on pcr_pkg
`default_nettype none

module pcr_div_pipe import pcr_pkg::*; (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire logic           valid_i,
  input  wire logic [DW-1:0]  dvs_i,
  input  wire logic [DVD-1:0] dvd_a_i,
  input  wire logic [DVD-1:0] dvd_b_i,
  input  wire side_t          side_i,
  output logic                valid_o,
  output logic [QW-1:0]       quo_a_o,
  output logic [QW-1:0]       quo_b_o,
  output logic                rnz_a_o,
  output logic                rnz_b_o,
  output side_t               side_o
);

  logic          valid_q [QW+1];
  logic [DW-1:0] dvs_q   [QW+1];
  side_t         side_q  [QW+1];
  logic [DW-1:0] rem_q   [QW+1][2];
  logic [QW-1:0] sr_q    [QW+1][2];
  logic [DVD-1:0] dvd_in [2];

  assign dvd_in[0] = dvd_a_i;
  assign dvd_in[1] = dvd_b_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else if (en_i) begin
      valid_q[0] <= valid_i;
    end
  end

  // top dividend bits start below the divisor since the quotient fits QW bits
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dvs_q[0]  <= dvs_i;
      side_q[0] <= side_i;
      for (int l = 0; l < 2; l++) begin
        rem_q[0][l] <= {1'b0, dvd_in[l][DVD-1 -: DW-1]};
        sr_q[0][l]  <= dvd_in[l][QW-1:0];
      end
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_step
    logic [DW:0]   t  [2];
    logic          ge [2];
    logic [DW-1:0] rn [2];
    logic [QW-1:0] sn [2];

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        t[l]  = {rem_q[k-1][l], sr_q[k-1][l][QW-1]};
        ge[l] = t[l] >= {1'b0, dvs_q[k-1]};
        rn[l] = ge[l] ? DW'(t[l] - {1'b0, dvs_q[k-1]}) : t[l][DW-1:0];
        sn[l] = {sr_q[k-1][l][QW-2:0], ge[l]};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= valid_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dvs_q[k]  <= dvs_q[k-1];
        side_q[k] <= side_q[k-1];
        for (int l = 0; l < 2; l++) begin
          rem_q[k][l] <= rn[l];
          sr_q[k][l]  <= sn[l];
        end
      end
    end
  end

  assign valid_o = valid_q[QW];
  assign quo_a_o = sr_q[QW][0];
  assign quo_b_o = sr_q[QW][1];
  assign rnz_a_o = |rem_q[QW][0];
  assign rnz_b_o = |rem_q[QW][1];
  assign side_o  = side_q[QW];

endmodule

`default_nettype wire

// ----- rtl/particle_contact_resolver.sv -----
// particle_contact_resolver: pipelined impulse and penetration solver for one contact a beat
// depends on pcr_pkg, pcr_if and pcr_div_pipe
//
// Takes one contact beat per clock while the result side is not stalled and returns one
// result beat for each accepted contact. The divider resolves one quotient bit of the
// mass-ratio split per pipeline stage; seven stages of dot products and multiplies go
// before it and three of scaling and saturation after. A stall on the result side holds
// the whole pipeline in place. The time step register must be written only while the
// pipeline is empty.
`default_nettype none

module particle_contact_resolver import pcr_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    cfg_we_i,
  input  wire logic [TW-1:0] cfg_data_i,
  pcr_contact_if.sink  contact,
  pcr_result_if.source result
);

  localparam logic signed [QPW-1:0] LIM =
    {{(QPW-PROD_LIM_SH-1){1'b0}}, 1'b1, {PROD_LIM_SH{1'b0}}};

  logic          en;
  logic [TW-1:0] dt_q;
  logic signed [TW:0] dt_s;
  logic [7:1]    v_q;

  carry_t c1_d, c1_q, c2_q, c3_q, c4_q, c5_q, c6_q, c7_q;
  logic signed [PW-1:0]   vp1_d [3];
  logic signed [PW-1:0]   ap1_d [3];
  logic signed [PW-1:0]   vp1_q [3];
  logic signed [PW-1:0]   ap1_q [3];
  logic signed [DOTW-1:0] sep2_q, acc2_q, sep3_q, sep4_q;
  logic signed [ACCW-1:0] accp3_q;
  logic signed [TDTW-1:0] tdt4_q;
  logic                   neg4_q;
  logic signed [SEPW-1:0] sepc5_d, sepc5_q, sum5;
  logic signed [FACW-1:0] fac6;
  logic signed [NPW-1:0]  np6_q, num7, mag7;
  logic [NMW-1:0]         nmag7_q;
  logic                   nneg7_q;

  side_t          side_in, side_dv;
  logic           dv_valid;
  logic [QW-1:0]  quo_a, quo_b;
  logic           rnz_a, rnz_b;

  logic                 p1v_q, p2v_q, res_valid_q;
  side_t                side1_q, side2_q;
  logic signed [QSW-1:0] qa1_q, qb1_q;
  logic signed [CW-1:0]  ma1_q, mb1_q;
  logic [QW-1:0]         qb_mag;
  logic [CW-2:0]         mb_mag;
  logic signed [QPW-1:0] dva2_q [3];
  logic signed [QPW-1:0] dvb2_q [3];
  logic signed [PW-1:0]  dpa2_q [3];
  logic signed [PW-1:0]  dpb2_q [3];

  logic [VW-1:0] va_pk, vb_pk, pa_pk, pb_pk;
  logic [VW-1:0] res_vel_a_q, res_vel_b_q, res_pos_a_q, res_pos_b_q;

  assign en            = !res_valid_q || result.ready;
  assign contact.ready = en;
  assign dt_s          = {1'b0, dt_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q <= TIME_STEP_RESET;
    end else if (cfg_we_i) begin
      dt_q <= cfg_data_i;
    end
  end

  // stage 1: component differences times normal
  always_comb begin
    logic signed [CW-1:0] a, b, n;
    logic signed [CW:0]   d;
    c1_d.vel_a = contact.vel_a;
    c1_d.vel_b = contact.vel_b;
    c1_d.pos_a = contact.pos_a;
    c1_d.pos_b = contact.pos_b;
    c1_d.nrm   = contact.contact_normal;
    c1_d.im_a  = contact.inv_mass_a;
    c1_d.den   = DW'(contact.inv_mass_a) +
                 (contact.has_b ? DW'(contact.inv_mass_b) : DW'(0));
    c1_d.e     = contact.restitution;
    c1_d.p     = contact.penetration_depth;
    c1_d.has   = contact.has_b;
    for (int c = 0; c < 3; c++) begin
      n = comp_get(contact.contact_normal, c);
      a = comp_get(contact.vel_a, c);
      b = contact.has_b ? comp_get(contact.vel_b, c) : '0;
      d = {a[CW-1], a} - {b[CW-1], b};
      vp1_d[c] = d * n;
      a = comp_get(contact.acc_a, c);
      b = contact.has_b ? comp_get(contact.acc_b, c) : '0;
      d = {a[CW-1], a} - {b[CW-1], b};
      ap1_d[c] = d * n;
    end
  end

  // stage 5: acceleration term and clamp
  always_comb begin
    sum5 = SEPW'(sep4_q) + SEPW'(tdt4_q >>> TW);
    if (neg4_q) begin
      sepc5_d = sum5[SEPW-1] ? '0 : sum5;
    end else begin
      sepc5_d = SEPW'(sep4_q);
    end
  end

  assign fac6 = FACW'({2'b00, c5_q.e}) + FACW'(32'd65536);
  assign num7 = np6_q >>> TW;
  assign mag7 = np6_q[NPW-1] ? -num7 : num7;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[6:1], contact.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c1_q <= c1_d;
      for (int c = 0; c < 3; c++) begin
        vp1_q[c] <= vp1_d[c];
        ap1_q[c] <= ap1_d[c];
      end
      c2_q    <= c1_q;
      sep2_q  <= DOTW'(vp1_q[0]) + DOTW'(vp1_q[1]) + DOTW'(vp1_q[2]);
      acc2_q  <= DOTW'(ap1_q[0]) + DOTW'(ap1_q[1]) + DOTW'(ap1_q[2]);
      c3_q    <= c2_q;
      sep3_q  <= sep2_q;
      accp3_q <= acc2_q * dt_s;
      c4_q    <= c3_q;
      sep4_q  <= sep3_q;
      neg4_q  <= accp3_q[ACCW-1];
      tdt4_q  <= (accp3_q >>> TW) * dt_s;
      c5_q    <= c4_q;
      sepc5_q <= sepc5_d;
      c6_q    <= c5_q;
      np6_q   <= sepc5_q * fac6;
      c7_q    <= c6_q;
      nneg7_q <= np6_q[NPW-1];
      nmag7_q <= mag7[NMW-1:0];
    end
  end

  always_comb begin
    side_in.vel_a    = c7_q.vel_a;
    side_in.vel_b    = c7_q.vel_b;
    side_in.pos_a    = c7_q.pos_a;
    side_in.pos_b    = c7_q.pos_b;
    side_in.nrm      = c7_q.nrm;
    side_in.has      = c7_q.has;
    side_in.den_zero = (c7_q.den == '0);
    side_in.pneg     = c7_q.p[CW-1];
    side_in.nneg     = nneg7_q;
    side_in.nmag     = nmag7_q;
    side_in.pmag     = c7_q.p[CW-2:0];
  end

  pcr_div_pipe u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v_q[7]),
    .dvs_i   (c7_q.den),
    .dvd_a_i (DVD'(nmag7_q) * DVD'(c7_q.im_a)),
    .dvd_b_i (DVD'(c7_q.p[CW-2:0]) * DVD'(c7_q.im_a)),
    .side_i  (side_in),
    .valid_o (dv_valid),
    .quo_a_o (quo_a),
    .quo_b_o (quo_b),
    .rnz_a_o (rnz_a),
    .rnz_b_o (rnz_b),
    .side_o  (side_dv)
  );

  // share of b is the rest of the numerator, rounded the other way
  assign qb_mag = side_dv.nmag - quo_a - QW'(rnz_a);
  assign mb_mag = side_dv.pmag - quo_b[CW-2:0] - (CW-1)'(rnz_b);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1v_q       <= 1'b0;
      p2v_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else if (en) begin
      p1v_q       <= dv_valid;
      p2v_q       <= p1v_q;
      res_valid_q <= p2v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side1_q <= side_dv;
      qa1_q   <= side_dv.nneg ? -QSW'(quo_a) : QSW'(quo_a);
      qb1_q   <= side_dv.nneg ? -QSW'(qb_mag) : QSW'(qb_mag);
      ma1_q   <= {1'b0, quo_b[CW-2:0]};
      mb1_q   <= {1'b0, mb_mag};
      side2_q <= side1_q;
      for (int c = 0; c < 3; c++) begin
        dva2_q[c] <= qa1_q * comp_get(side1_q.nrm, c);
        dvb2_q[c] <= qb1_q * comp_get(side1_q.nrm, c);
        dpa2_q[c] <= ma1_q * comp_get(side1_q.nrm, c);
        dpb2_q[c] <= mb1_q * comp_get(side1_q.nrm, c);
      end
    end
  end

  // stage after products: clamp, scale back, add and saturate
  always_comb begin
    logic signed [QPW-1:0] ca, cb;
    for (int c = 0; c < 3; c++) begin
      ca = (dva2_q[c] > LIM) ? LIM : ((dva2_q[c] < -LIM) ? -LIM : dva2_q[c]);
      cb = (dvb2_q[c] > LIM) ? LIM : ((dvb2_q[c] < -LIM) ? -LIM : dvb2_q[c]);
      va_pk[c*CW +: CW] = sat_c(SUMW'(comp_get(side2_q.vel_a, c)) - SUMW'(ca >>> (2 * FB)));
      vb_pk[c*CW +: CW] = sat_c(SUMW'(comp_get(side2_q.vel_b, c)) + SUMW'(cb >>> (2 * FB)));
      pa_pk[c*CW +: CW] = sat_c(SUMW'(comp_get(side2_q.pos_a, c)) - SUMW'(dpa2_q[c] >>> FB));
      pb_pk[c*CW +: CW] = sat_c(SUMW'(comp_get(side2_q.pos_b, c)) + SUMW'(dpb2_q[c] >>> FB));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (side2_q.den_zero) begin
        res_vel_a_q <= side2_q.vel_a;
        res_vel_b_q <= side2_q.vel_b;
        res_pos_a_q <= side2_q.pos_a;
        res_pos_b_q <= side2_q.pos_b;
      end else begin
        res_vel_a_q <= va_pk;
        res_pos_a_q <= side2_q.pneg ? side2_q.pos_a : pa_pk;
        res_vel_b_q <= side2_q.has ? vb_pk : side2_q.vel_b;
        res_pos_b_q <= (side2_q.has && !side2_q.pneg) ? pb_pk : side2_q.pos_b;
      end
    end
  end

  assign result.valid     = res_valid_q;
  assign result.new_vel_a = res_vel_a_q;
  assign result.new_vel_b = res_vel_b_q;
  assign result.new_pos_a = res_pos_a_q;
  assign result.new_pos_b = res_pos_b_q;

endmodule

`default_nettype wire
